// ----- design/prewitt_edge_magnitude_macros.svh -----
// Assertion macros shared by the edge magnitude design files.
`ifndef PREWITT_EDGE_MAGNITUDE_MACROS_SVH
`define PREWITT_EDGE_MAGNITUDE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PRW_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define PRW_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define PRW_ASSERT(lbl, cond)
`define PRW_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- design/prw_pkg.sv -----
// Shared constants and types for the Prewitt edge magnitude block.
`timescale 1ns / 1ps
package prw_pkg;
	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int IMG_W_W = 12;
	localparam int IMG_H_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;
	localparam logic [9:0] COEF_R = 10'd299;
	localparam logic [9:0] COEF_G = 10'd587;
	localparam logic [9:0] COEF_B = 10'd114;
	localparam logic [9:0] GRAY_DIV = 10'd1000;
	// floor(2^18/1000): estimate is at most one below the true quotient
	localparam logic [8:0] GRAY_RECIP = 9'd262;
	localparam int GRAY_SHIFT = 18;
	localparam int SUM_W = 18;
	localparam int SQ_W = 16;

	typedef struct packed {
		logic             wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [15:0]      wr_data;
		logic             rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} lsc_t;
endpackage

// ----- design/prw_line_store.sv -----
// Gray line stores: row above in the low byte, row two above in the high byte.
`timescale 1ns / 1ps
module prw_line_store (
	input  logic            clk,
	input  prw_pkg::lsc_t   ctl,
	output logic [15:0]     rd_data
);
	logic [15:0] mem [prw_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[ctl.rd_addr];
		end
	end
endmodule

// ----- design/prw_isqrt.sv -----
// Iterative floor square root of a 16-bit value, one result bit per step.
`timescale 1ns / 1ps
module prw_isqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [prw_pkg::SQ_W-1:0] value,
	output logic                     done,
	output logic [7:0]               root
);
	logic [prw_pkg::SQ_W-1:0] v_q;
	logic [prw_pkg::SQ_W-1:0] res_q;
	logic [prw_pkg::SQ_W-1:0] bit_q;
	logic                     busy_q;
	logic                     done_q;
	logic [prw_pkg::SQ_W:0]   trial;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			res_q <= '0;
			bit_q <= prw_pkg::SQ_W'(1) << (prw_pkg::SQ_W - 2);
		end else if (busy_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= v_q - trial[prw_pkg::SQ_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[7:0];

	`include "prewitt_edge_magnitude_macros.svh"
	`PRW_ASSERT(a_no_start_busy, !(start && busy_q))
	`PRW_ASSERT_NEXT(a_done_pulse, done_q, !done_q)
	`PRW_ASSERT(a_done_fits, !done_q || res_q[prw_pkg::SQ_W-1:8] == '0)
endmodule

// ----- design/prewitt_edge_magnitude.sv -----
// Top level: gray conversion, line stores, 3x3 window and Prewitt magnitude.
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata {red,green,blue}, tuser op
// m_*       out  m_tvalid/m_tready  tdata magnitude, tlast row_end, tuser image_end
// cfg_*     in   cfg_valid/cfg_ready index, data (always ready)
// One item at a time: the sequencer walks gray divide, line store read-modify-write
// and the 8-step square root unit before the next item is taken; an ignored item
// is dropped without leaving idle.
// No clearing pass after reset. A stalled m_tready holds the sequencer only when
// a new result needs the output register.
`timescale 1ns / 1ps
module prewitt_edge_magnitude (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,  // red, green, blue
	input  logic                            s_tuser,  // op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,  // magnitude
	output logic                            m_tlast,  // row_end
	output logic                            m_tuser,  // image_end
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [prw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [prw_pkg::CFG_DATA_W-1:0]  cfg_data
);
	localparam int AW = prw_pkg::ADDR_W;
	localparam int WW = prw_pkg::IMG_W_W;
	localparam int HW = prw_pkg::IMG_H_W;

	typedef enum logic [3:0] {
		S_IDLE, S_GRAY, S_FIX, S_PUSH, S_RPT, S_GRAD, S_SQ, S_SQRT, S_OUT
	} state_t;

	state_t state_q;
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [AW-1:0] col_q, drain_q;
	logic [HW-1:0] row_q;
	logic [7:0] win_q [9];
	logic op_q, pend_q, row_end_q, image_end_q;
	logic [prw_pkg::SUM_W-1:0] sum_q;
	logic [7:0] q0_q, gray_q, mag_q;
	logic [15:0] rd_q;
	logic [9:0] ax_q, ay_q;
	logic m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [7:0] m_tdata_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic accept, ignore, load_out, sq_start, sq_done;
	logic [7:0] root;
	logic [15:0] rd_data;
	prw_pkg::lsc_t lsc;
	logic [AW-1:0] idx;
	logic is_last;
	logic [7:0] mid, top, bot;
	logic [26:0] est;
	logic [17:0] q0x;
	logic [17:0] rem;
	logic signed [11:0] gx, gy;
	logic [20:0] sq;

	always_comb begin
		w_eff = width_q;
		if (width_q == '0) w_eff = WW'(1);
		else if (width_q > WW'(prw_pkg::MAX_WIDTH)) w_eff = WW'(prw_pkg::MAX_WIDTH);
		h_eff = (height_q == '0) ? HW'(1) : height_q;
	end

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign ignore = (s_tuser == prw_pkg::OP_PIXEL) ? (row_q >= h_eff) : (row_q < h_eff);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WW'(640);
			height_q <= HW'(480);
		end else if (cfg_valid) begin
			case (cfg_index)
				prw_pkg::REG_IMAGE_WIDTH:  width_q <= cfg_data[WW-1:0];
				prw_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[HW-1:0];
				default: ;
			endcase
		end
	end

	// line store access: read at accept, write back during the window push of a pixel
	assign idx = op_q ? drain_q : col_q;
	always_comb begin
		lsc.rd_en = accept;
		lsc.rd_addr = (s_tuser == prw_pkg::OP_DRAIN) ? drain_q : col_q;
		lsc.wr_en = (state_q == S_PUSH) && (op_q == prw_pkg::OP_PIXEL);
		lsc.wr_addr = col_q;
		lsc.wr_data = {rd_q[7:0], gray_q};
	end

	prw_line_store u_store (.clk(clk), .ctl(lsc), .rd_data(rd_data));

	assign is_last = ({1'b0, idx} + WW'(1)) >= w_eff;
	assign mid = rd_q[7:0];
	always_comb begin
		if (op_q == prw_pkg::OP_PIXEL) begin
			top = (row_q <= HW'(1)) ? mid : rd_q[15:8];
			bot = gray_q;
		end else begin
			top = (h_eff == HW'(1)) ? mid : rd_q[15:8];
			bot = mid;
		end
	end

	assign est = 27'(sum_q) * 27'(prw_pkg::GRAY_RECIP);
	assign q0x = 18'(q0_q) * 18'(prw_pkg::GRAY_DIV);
	assign rem = sum_q - q0x;

	assign gx = 12'(win_q[2]) + 12'(win_q[5]) + 12'(win_q[8])
		- 12'(win_q[0]) - 12'(win_q[3]) - 12'(win_q[6]);
	assign gy = 12'(win_q[6]) + 12'(win_q[7]) + 12'(win_q[8])
		- 12'(win_q[0]) - 12'(win_q[1]) - 12'(win_q[2]);
	assign sq = 21'(ax_q) * 21'(ax_q) + 21'(ay_q) * 21'(ay_q);
	assign sq_start = (state_q == S_SQ);

	prw_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.value((sq > 21'd65535) ? 16'hFFFF : sq[15:0]),
		.done(sq_done), .root(root)
	);

	assign load_out = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q <= '0;
			row_q <= '0;
			drain_q <= '0;
			pend_q <= 1'b0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tlast_q <= 1'b0;
			m_tuser_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (accept && !ignore) state_q <= S_GRAY;
				S_GRAY: state_q <= S_FIX;
				S_FIX:  state_q <= S_PUSH;
				S_PUSH: begin
					for (int r = 0; r < 3; r++) begin
						win_q[r*3]   <= (idx == '0) ? ((r == 0) ? top : (r == 1) ? mid : bot)
							: win_q[r*3+1];
						win_q[r*3+1] <= (idx == '0) ? ((r == 0) ? top : (r == 1) ? mid : bot)
							: win_q[r*3+2];
						win_q[r*3+2] <= (r == 0) ? top : (r == 1) ? mid : bot;
					end
					if (op_q == prw_pkg::OP_PIXEL) begin
						pend_q <= (row_q != '0) && is_last;
						if ((row_q != '0) && (col_q != '0)) state_q <= S_GRAD;
						else if ((row_q != '0) && is_last) state_q <= S_RPT;
						else state_q <= S_IDLE;
						if (is_last) begin
							col_q <= '0;
							row_q <= row_q + HW'(1);
						end else begin
							col_q <= col_q + AW'(1);
						end
					end else begin
						pend_q <= is_last;
						if (drain_q != '0) state_q <= S_GRAD;
						else if (is_last) state_q <= S_RPT;
						else state_q <= S_IDLE;
						if (is_last) begin
							drain_q <= '0;
							row_q <= '0;
							col_q <= '0;
						end else begin
							drain_q <= drain_q + AW'(1);
						end
					end
				end
				S_RPT: begin
					for (int r = 0; r < 3; r++) begin
						win_q[r*3] <= win_q[r*3+1];
						win_q[r*3+1] <= win_q[r*3+2];
					end
					pend_q <= 1'b0;
					state_q <= S_GRAD;
				end
				S_GRAD: state_q <= S_SQ;
				S_SQ:   state_q <= S_SQRT;
				S_SQRT: if (sq_done) state_q <= S_OUT;
				S_OUT:  if (load_out) state_q <= pend_q ? S_RPT : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (load_out) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q <= mag_q;
				m_tlast_q <= row_end_q;
				m_tuser_q <= image_end_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= s_tuser;
			sum_q <= 18'(s_tdata[23:16]) * 18'(prw_pkg::COEF_R)
				+ 18'(s_tdata[15:8]) * 18'(prw_pkg::COEF_G)
				+ 18'(s_tdata[7:0]) * 18'(prw_pkg::COEF_B);
		end
		if (state_q == S_GRAY) begin
			rd_q <= rd_data;
			q0_q <= est[prw_pkg::GRAY_SHIFT+7:prw_pkg::GRAY_SHIFT];
		end
		if (state_q == S_FIX) begin
			gray_q <= (rem >= 18'(prw_pkg::GRAY_DIV)) ? q0_q + 8'd1 : q0_q;
		end
		if (state_q == S_PUSH) begin
			row_end_q <= 1'b0;
			image_end_q <= 1'b0;
		end
		if (state_q == S_RPT) begin
			row_end_q <= 1'b1;
			image_end_q <= (op_q == prw_pkg::OP_DRAIN);
		end
		if (state_q == S_GRAD) begin
			ax_q <= gx[11] ? 10'(-gx) : gx[9:0];
			ay_q <= gy[11] ? 10'(-gy) : gy[9:0];
		end
		if (sq_done) begin
			mag_q <= root;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;
	assign m_tuser = m_tuser_q;

	`include "prewitt_edge_magnitude_macros.svh"
	`PRW_ASSERT(a_done_in_sqrt, !sq_done || state_q == S_SQRT)
	`PRW_ASSERT(a_load_free, !load_out || !m_tvalid_q || m_tready)
	`PRW_ASSERT_NEXT(a_accept_reads, accept && !ignore, state_q == S_GRAY)
	`PRW_ASSERT(a_write_pixel_only, !lsc.wr_en || op_q == prw_pkg::OP_PIXEL)
endmodule
